/* rtl/core/tile_ring_writer_with_clear_mask_top_assert.svh */
// Assertion macros used by the tile ring writer back end.
// Included by files that check their own logic; no other dependencies.
`ifndef TILE_RING_WRITER_WITH_CLEAR_MASK_TOP_ASSERT_SVH
`define TILE_RING_WRITER_WITH_CLEAR_MASK_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TRWCM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trwcm assertion failed");
`define TRWCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trwcm assertion failed");
`else
`define TRWCM_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define TRWCM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/trwcm_pkg.sv */
// Package for the tile ring writer: field widths, command and job codes,
// payload structs. No dependencies.
package trwcm_pkg;

   localparam int ADDR_W  = 16;
   localparam int COORD_W = 16;
   localparam int TILE_W  = 8;
   localparam int CMD_W   = 2;
   localparam int KEY_W   = 2 * COORD_W;
   localparam int CSR_W   = 32;
   localparam int PADDR_W = 2;
   localparam int JOB_W   = 3;

   localparam int RING_COLS_DEF      = 64;
   localparam int RING_ROWS_DEF      = 32;
   localparam int CLEAR_CAPACITY_DEF = 256;

   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GAME  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // job kinds decided by the front end
   localparam logic [JOB_W-1:0] JOB_LOAD  = 3'd0;  // masked by table lookup
   localparam logic [JOB_W-1:0] JOB_WRITE = 3'd1;  // game write, nonzero tile
   localparam logic [JOB_W-1:0] JOB_MARK  = 3'd2;  // game write, zero tile
   localparam logic [JOB_W-1:0] JOB_CLEAR = 3'd3;
   localparam logic [JOB_W-1:0] JOB_NONE  = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [COORD_W-1:0] world_x;
      logic [COORD_W-1:0] world_y;
      logic [TILE_W-1:0]  tile_in;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] ring_address;
      logic [TILE_W-1:0] tile_out;
      logic              write_valid;
      logic              table_full;
   } rsp_type;

   typedef struct packed {
      logic [JOB_W-1:0]   kind;
      logic [COORD_W-1:0] world_x;
      logic [COORD_W-1:0] world_y;
      logic [TILE_W-1:0]  tile;
      logic [ADDR_W-1:0]  addr;
   } job_type;

endpackage

/* rtl/core/trwcm_front.sv */
// Front end: accepts requests, reduces x and y modulo the ring size by
// reciprocal multiplication, forms the ring address and classifies the job. Uses trwcm_pkg.
module trwcm_front #(
   parameter int RING_COLS = trwcm_pkg::RING_COLS_DEF,
   parameter int RING_ROWS = trwcm_pkg::RING_ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  trwcm_pkg::req_type          req_data,
   input  logic [trwcm_pkg::ADDR_W-1:0] ring_base,
   output logic                        push_valid,
   input  logic                        push_ready,
   output trwcm_pkg::job_type          push_data
);

   localparam int AW      = trwcm_pkg::ADDR_W;
   localparam int CW      = trwcm_pkg::COORD_W;
   localparam int PW      = CW + 32;
   localparam int XRW     = $clog2(RING_COLS) + 1;
   localparam int YRW     = $clog2(RING_ROWS) + 1;
   localparam int JOB_W_L = trwcm_pkg::JOB_W;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_QUO  = 2'd1;
   localparam logic [1:0] F_REM  = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   // floor(2^32 / n): the quotient estimate is exact or one short
   localparam logic [31:0] RECIP_X = 32'((64'd1 << 32) / RING_COLS);
   localparam logic [31:0] RECIP_Y = 32'((64'd1 << 32) / RING_ROWS);

   localparam logic [CW-1:0] COLS_C = CW'(RING_COLS);
   localparam logic [CW-1:0] ROWS_C = CW'(RING_ROWS);
   localparam logic [AW-1:0] COLS_A = AW'(RING_COLS);

   logic [1:0]          state_ff, state_in;
   trwcm_pkg::req_type  hold_ff, hold_in;
   logic [CW-1:0]       xq_ff, xq_in, yq_ff, yq_in;
   logic [XRW-1:0]      xrem_ff, xrem_in;
   logic [YRW-1:0]      yrem_ff, yrem_in;
   logic [PW-1:0]       xprod, yprod;
   logic [CW-1:0]       xdiff, ydiff;
   logic [JOB_W_L-1:0]  kind;

   assign req_ready = (state_ff == F_IDLE);

   assign xprod = PW'(hold_ff.world_x) * PW'(RECIP_X);
   assign yprod = PW'(hold_ff.world_y) * PW'(RECIP_Y);

   // estimated remainder, below twice the divisor
   assign xdiff = hold_ff.world_x - xq_ff * COLS_C;
   assign ydiff = hold_ff.world_y - yq_ff * ROWS_C;

   always_comb begin
      priority if (hold_ff.command == trwcm_pkg::CMD_LOAD) begin
         kind = trwcm_pkg::JOB_LOAD;
      end else if (hold_ff.command == trwcm_pkg::CMD_GAME) begin
         kind = (hold_ff.tile_in == '0) ? trwcm_pkg::JOB_MARK : trwcm_pkg::JOB_WRITE;
      end else if (hold_ff.command == trwcm_pkg::CMD_CLEAR) begin
         kind = trwcm_pkg::JOB_CLEAR;
      end else begin
         kind = trwcm_pkg::JOB_NONE;
      end
   end

   always_comb begin
      push_data.kind    = kind;
      push_data.world_x = hold_ff.world_x;
      push_data.world_y = hold_ff.world_y;
      push_data.tile    = hold_ff.tile_in;
      push_data.addr    = ring_base + AW'(yrem_ff) * COLS_A + AW'(xrem_ff);
   end

   assign push_valid = (state_ff == F_PUSH);

   always_comb begin
      state_in = state_ff;
      hold_in  = hold_ff;
      xq_in    = xq_ff;
      yq_in    = yq_ff;
      xrem_in  = xrem_ff;
      yrem_in  = yrem_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               hold_in  = req_data;
               state_in = F_QUO;
            end
         end
         F_QUO: begin
            xq_in    = xprod[PW-1:32];
            yq_in    = yprod[PW-1:32];
            state_in = F_REM;
         end
         F_REM: begin
            xrem_in  = (xdiff >= COLS_C) ? XRW'(xdiff - COLS_C) : XRW'(xdiff);
            yrem_in  = (ydiff >= ROWS_C) ? YRW'(ydiff - ROWS_C) : YRW'(ydiff);
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      hold_ff <= hold_in;
      xq_ff   <= xq_in;
      yq_ff   <= yq_in;
      xrem_ff <= xrem_in;
      yrem_ff <= yrem_in;
   end

endmodule

/* rtl/core/trwcm_queue.sv */
// Two-entry job queue between front and back end. Uses trwcm_pkg.
module trwcm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  trwcm_pkg::job_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output trwcm_pkg::job_type pop_data
);

   trwcm_pkg::job_type ent_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_fire, pop_fire;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = ent_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push_fire && !pop_fire) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop_fire && !push_fire) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push_fire) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop_fire) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
      if (push_fire) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/core/trwcm_back.sv */
// Back end: scans the cleared-position table, records zero game writes,
// empties the table on clear and drives the result register. Uses trwcm_pkg.
`include "tile_ring_writer_with_clear_mask_top_assert.svh"
module trwcm_back #(
   parameter int CLEAR_CAPACITY = trwcm_pkg::CLEAR_CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  trwcm_pkg::job_type job_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output trwcm_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CLEAR_CAPACITY + 1);
   localparam int IDX_W = (CLEAR_CAPACITY > 1) ? $clog2(CLEAR_CAPACITY) : 1;
   localparam int KW    = trwcm_pkg::KEY_W;

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_SCAN = 2'd1;
   localparam logic [1:0] B_DONE = 2'd2;

   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CLEAR_CAPACITY);
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

   logic [KW-1:0]      mem [CLEAR_CAPACITY];
   logic [1:0]         state_ff, state_in;
   trwcm_pkg::job_type cur_ff, cur_in;
   logic [CNT_W-1:0]   count_ff, count_in, scan_ff, scan_in;
   logic               pend_ff, pend_in, found_ff, found_in;
   logic [KW-1:0]      rd_ff, key;
   logic               rd_en, mem_we, hit, done_fire, full_res, clear_fire;
   logic               rsp_valid_ff;
   trwcm_pkg::rsp_type rsp_ff, rsp_in;

   assign key        = {cur_ff.world_y, cur_ff.world_x};
   assign hit        = pend_ff && (rd_ff == key);
   assign job_ready  = (state_ff == B_IDLE);
   assign done_fire  = (state_ff == B_DONE) && (!rsp_valid_ff || rsp_ready);
   assign clear_fire = done_fire && (cur_ff.kind == trwcm_pkg::JOB_CLEAR);
   assign full_res   = (cur_ff.kind == trwcm_pkg::JOB_MARK) && !found_ff
                       && (count_ff == CAP_C);
   assign mem_we     = done_fire && (cur_ff.kind == trwcm_pkg::JOB_MARK) && !found_ff
                       && (count_ff < CAP_C);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      rsp_in = '0;
      unique case (cur_ff.kind)
         trwcm_pkg::JOB_LOAD: begin
            rsp_in.ring_address = cur_ff.addr;
            rsp_in.tile_out     = found_ff ? '0 : cur_ff.tile;
            rsp_in.write_valid  = 1'b1;
         end
         trwcm_pkg::JOB_WRITE, trwcm_pkg::JOB_MARK: begin
            rsp_in.ring_address = cur_ff.addr;
            rsp_in.tile_out     = cur_ff.tile;
            rsp_in.write_valid  = 1'b1;
            rsp_in.table_full   = full_res;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      count_in = count_ff;
      scan_in  = scan_ff;
      pend_in  = pend_ff;
      found_in = found_ff;
      rd_en    = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               cur_in   = job_data;
               scan_in  = '0;
               pend_in  = 1'b0;
               found_in = 1'b0;
               if (job_data.kind == trwcm_pkg::JOB_LOAD ||
                   job_data.kind == trwcm_pkg::JOB_MARK) begin
                  state_in = B_SCAN;
               end else begin
                  state_in = B_DONE;
               end
            end
         end
         B_SCAN: begin
            // issue one read per cycle, compare the previous one
            priority if (hit) begin
               found_in = 1'b1;
               state_in = B_DONE;
            end else if (scan_ff < count_ff) begin
               rd_en   = 1'b1;
               scan_in = scan_ff + ONE_C;
               pend_in = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (done_fire) begin
               state_in = B_IDLE;
               if (cur_ff.kind == trwcm_pkg::JOB_CLEAR) begin
                  count_in = '0;
               end else if (mem_we) begin
                  count_in = count_ff + ONE_C;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         if (done_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      cur_ff   <= cur_in;
      scan_ff  <= scan_in;
      found_ff <= found_in;
      if (done_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[scan_ff[IDX_W-1:0]];
      end
      if (mem_we) begin
         mem[count_ff[IDX_W-1:0]] <= key;
      end
   end

   `TRWCM_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CAP_C)
   `TRWCM_ASSERT_IMPLIES(a_scan_bound, clock, reset, rd_en, scan_ff < count_ff)
   `TRWCM_ASSERT_NEXT(a_clear_empties, clock, reset, clear_fire, count_ff == '0)
   `TRWCM_ASSERT_IMPLIES(a_full_flag, clock, reset, done_fire && rsp_in.table_full, count_ff == CAP_C && !mem_we)

endmodule

/* rtl/core/tile_ring_writer_with_clear_mask_top.sv */
// Every item passes the front end's quotient, remainder and push states and the job
// queue; for a clear, a nonzero game write or the unused code the back end's done state
// then loads the result register, while a load or zero game write first scans the table,
// reading each held entry in turn and stopping on a match. The front end takes no new
// request until it has pushed the last one; a scan holds the back end until it ends.
// Reset is synchronous: it empties the table, clears ring_base and all handshakes.
module tile_ring_writer_with_clear_mask_top #(
   parameter int RING_COLS      = trwcm_pkg::RING_COLS_DEF,
   parameter int RING_ROWS      = trwcm_pkg::RING_ROWS_DEF,
   parameter int CLEAR_CAPACITY = trwcm_pkg::CLEAR_CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  trwcm_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output trwcm_pkg::rsp_type            rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [trwcm_pkg::PADDR_W-1:0] csr_paddr,
   input  logic [trwcm_pkg::CSR_W-1:0]   csr_pwdata,
   output logic [trwcm_pkg::CSR_W-1:0]   csr_prdata,
   output logic                          csr_pready
);

   localparam int AW = trwcm_pkg::ADDR_W;
   localparam int DW = trwcm_pkg::CSR_W;

   logic [AW-1:0]      base_ff;
   logic               push_valid, push_ready, job_valid, job_ready;
   trwcm_pkg::job_type push_data, job_data;

   // single register; the byte offset within the word is ignored
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == '0) ? DW'(base_ff) : DW'(base_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         base_ff <= csr_pwdata[AW-1:0];
      end
   end

   trwcm_front #(
      .RING_COLS (RING_COLS),
      .RING_ROWS (RING_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .ring_base  (base_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   trwcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_data   (job_data)
   );

   trwcm_back #(
      .CLEAR_CAPACITY (CLEAR_CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job_data  (job_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for tile_ring_writer_with_clear_mask_top: predicts ring address, masked tile
// and table-full flag per transfer, and checks them in order. Depends on trwcm_pkg and the top.
module tb_top;
   import trwcm_pkg::*;

   localparam logic [CMD_W-1:0]   CMD_UNUSED    = 2'd3;
   localparam logic [PADDR_W-1:0] CSR_RING_BASE = 2'd0;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int POOL_SIZE   = 12;
   localparam int TAIL_WAIT   = 300;

   // Tracks the cleared-position table and ring base, and holds pending ring writes.
   class ring_write_tracker;
      logic [ADDR_W-1:0] ring_base;
      logic [KEY_W-1:0]  cleared_keys[CLEAR_CAPACITY_DEF];
      int unsigned       cleared_count;
      rsp_type           pending_writes[$];
      int unsigned       errors, checked, masked_loads, full_drops, clears;

      function new();
         ring_base     = '0;
         cleared_count = 0;
      endfunction

      function int pending();
         return pending_writes.size();
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, what);
      endtask

      function void accept_request(req_type r);
         rsp_type          res;
         logic [KEY_W-1:0] key;
         int unsigned      slot;
         bit               hit;
         res = '0;
         key = {r.world_y, r.world_x};
         hit = 1'b0;
         for (int i = 0; i < cleared_count; i++)
            if (cleared_keys[i] == key)
               hit = 1'b1;
         case (r.command)
            CMD_LOAD, CMD_GAME: begin
               slot = int'(ring_base) + (int'(r.world_y) % RING_ROWS_DEF) * RING_COLS_DEF
                      + int'(r.world_x) % RING_COLS_DEF;
               res.ring_address = slot[ADDR_W-1:0];
               res.write_valid  = 1'b1;
               if (r.command == CMD_LOAD) begin
                  res.tile_out = hit ? '0 : r.tile_in;
                  if (hit)
                     masked_loads++;
               end else begin
                  res.tile_out = r.tile_in;
                  if (r.tile_in == '0 && !hit) begin
                     if (cleared_count < CLEAR_CAPACITY_DEF) begin
                        cleared_keys[cleared_count] = key;
                        cleared_count++;
                     end else begin
                        res.table_full = 1'b1;
                        full_drops++;
                     end
                  end
               end
            end
            CMD_CLEAR: begin
               cleared_count = 0;
               clears++;
            end
            default: ;
         endcase
         pending_writes.push_back(res);
      endfunction

      task check_ring_write(rsp_type got);
         rsp_type want;
         if (pending_writes.size() == 0) begin
            report($sformatf("result %h arrived with nothing pending", got));
            return;
         end
         want = pending_writes.pop_front();
         checked++;
         if (got.ring_address !== want.ring_address)
            report($sformatf("ring_address %h, predicted %h", got.ring_address,
                             want.ring_address));
         if (got.tile_out !== want.tile_out)
            report($sformatf("tile_out %h, predicted %h", got.tile_out, want.tile_out));
         if (got.write_valid !== want.write_valid)
            report($sformatf("write_valid %b, predicted %b", got.write_valid,
                             want.write_valid));
         if (got.table_full !== want.table_full)
            report($sformatf("table_full %b, predicted %b", got.table_full,
                             want.table_full));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [PADDR_W-1:0]  csr_paddr;
   logic [CSR_W-1:0]    csr_pwdata;
   logic [CSR_W-1:0]    csr_prdata;
   logic                csr_pready;

   ring_write_tracker   writes;
   bit                  idle_on = 1'b1;
   int unsigned         cycle_count = 0;
   int unsigned         items_sent = 0;
   int unsigned         base_settings = 0;
   int unsigned         stall_left = 0;
   logic [KEY_W-1:0]    pos_pool[POOL_SIZE];
   logic [KEY_W-1:0]    filled_pos[$];

   tile_ring_writer_with_clear_mask_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side backpressure: random stalls, started only while idling is enabled.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         writes.check_ring_write(rsp_data);
   end

   function automatic req_type make_item(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] x,
                                         logic [COORD_W-1:0] y, logic [TILE_W-1:0] t);
      req_type it;
      it.command = cmd;
      it.world_x = x;
      it.world_y = y;
      it.tile_in = t;
      return it;
   endfunction

   // Mostly positions from a small pool so loads hit recorded entries.
   function automatic req_type random_item();
      req_type          it;
      int               pick;
      logic [KEY_W-1:0] pos;
      pick = $urandom_range(0, 99);
      pos = ($urandom_range(0, 9) < 7) ? pos_pool[$urandom_range(0, POOL_SIZE - 1)]
                                       : KEY_W'($urandom);
      it.world_x = pos[COORD_W-1:0];
      it.world_y = pos[KEY_W-1:COORD_W];
      it.tile_in = TILE_W'($urandom);
      if (pick < 42) begin
         it.command = CMD_LOAD;
      end else if (pick < 88) begin
         it.command = CMD_GAME;
         if ($urandom_range(0, 1) == 1)
            it.tile_in = '0;
      end else if (pick < 96) begin
         it.command = CMD_CLEAR;
      end else begin
         it.command = CMD_UNUSED;
      end
      return it;
   endfunction

   // Leaves valid high after the transfer so back-to-back items need no gap.
   task automatic send_item(input req_type item);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      writes.accept_request(item);
      items_sent++;
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (writes.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [PADDR_W-1:0] addr, input logic [CSR_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [PADDR_W-1:0] addr, input logic [ADDR_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[ADDR_W-1:0] !== want)
         writes.report($sformatf("ring_base reads %h, written %h",
                                 csr_prdata[ADDR_W-1:0], want));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_ring_base(input logic [ADDR_W-1:0] value);
      csr_write(CSR_RING_BASE, CSR_W'(value));
      writes.ring_base = value;
      csr_check(CSR_RING_BASE, value);
      base_settings++;
   endtask

   initial begin
      logic [COORD_W-1:0] wx, wy;
      logic [KEY_W-1:0]   pick;
      writes      = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_data    <= '0;
      rsp_ready   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      pos_pool[0] = 32'hFFFF_FFFF;
      pos_pool[1] = 32'h0000_0000;
      pos_pool[2] = 32'h0000_FFFF;
      pos_pool[3] = 32'hFFFF_0000;
      for (int i = 4; i < POOL_SIZE; i++)
         pos_pool[i] = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: field extremes, masking, duplicates, ignored code, clear.
      program_ring_base(16'hFFFF);
      send_item(make_item(CMD_LOAD,   16'h0000, 16'h0000, 8'hFF));
      send_item(make_item(CMD_LOAD,   16'hFFFF, 16'hFFFF, 8'h00));
      send_item(make_item(CMD_GAME,   16'hFFFF, 16'hFFFF, 8'hAA));
      send_item(make_item(CMD_GAME,   16'h1234, 16'h5678, 8'h00));
      send_item(make_item(CMD_GAME,   16'h1234, 16'h5678, 8'h00));
      send_item(make_item(CMD_LOAD,   16'h1234, 16'h5678, 8'h55));
      send_item(make_item(CMD_LOAD,   16'h1234, 16'h5679, 8'h55));
      send_item(make_item(CMD_LOAD,   16'h1274, 16'h5678, 8'h55));
      send_item(make_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF));
      send_item(make_item(CMD_LOAD,   16'h1234, 16'h5678, 8'h66));
      send_item(make_item(CMD_CLEAR,  16'h1234, 16'h5678, 8'hFF));
      send_item(make_item(CMD_LOAD,   16'h1234, 16'h5678, 8'h66));
      send_item(make_item(CMD_GAME,   16'hFFFF, 16'hFFFF, 8'h00));
      send_item(make_item(CMD_LOAD,   16'hFFFF, 16'hFFFF, 8'hFF));
      send_item(make_item(CMD_GAME,   16'h0000, 16'h0000, 8'h01));
      send_item(make_item(CMD_GAME,   16'hAAAA, 16'h5555, 8'h80));
      send_item(make_item(CMD_LOAD,   16'h5555, 16'hAAAA, 8'h7F));
      wait_until_drained();

      // Fill the table past capacity with distinct positions.
      program_ring_base(16'h0000);
      send_item(make_item(CMD_CLEAR, 16'(($urandom)), 16'($urandom), 8'($urandom)));
      for (int i = 0; i < CLEAR_CAPACITY_DEF + 4; i++) begin
         wx = {7'($urandom), 9'(i)};
         wy = 16'($urandom);
         send_item(make_item(CMD_GAME, wx, wy, 8'h00));
         filled_pos.push_back({wy, wx});
         if (i % 16 == 15) begin
            pick = filled_pos[$urandom_range(0, filled_pos.size() - 1)];
            send_item(make_item(CMD_LOAD, pick[15:0], pick[31:16], 8'($urandom_range(1, 255))));
            send_item(make_item(CMD_GAME, pick[15:0], pick[31:16], 8'h00));
         end
      end
      pick = filled_pos[0];
      send_item(make_item(CMD_LOAD, pick[15:0], pick[31:16], 8'hC3));
      send_item(make_item(CMD_GAME, pick[15:0], pick[31:16], 8'h00));
      send_item(make_item(CMD_GAME, 16'hFE01, 16'h0101, 8'h3C));
      send_item(make_item(CMD_GAME, 16'hFE01, 16'h0101, 8'h00));
      send_item(make_item(CMD_CLEAR, 16'h0000, 16'h0000, 8'h00));
      send_item(make_item(CMD_LOAD, pick[15:0], pick[31:16], 8'hC3));
      wait_until_drained();

      // Mixed traffic with a full pause midway and a stretch with no idling.
      program_ring_base(16'($urandom));
      for (int i = 0; i < 110; i++) begin
         if (i == 55)
            wait_until_drained();
         idle_on = !(i >= 70 && i < 90);
         send_item(random_item());
      end
      wait_until_drained();

      // Closing part at full rate.
      idle_on = 1'b0;
      program_ring_base(16'($urandom));
      for (int i = 0; i < 40; i++)
         send_item(random_item());
      wait_until_drained();
      repeat (TAIL_WAIT) @(posedge clock);

      $display("Sent %0d items under %0d ring_base settings; %0d results checked.",
               items_sent, base_settings, writes.checked);
      $display("Seen %0d masked loads, %0d dropped positions on a full table, %0d clears.",
               writes.masked_loads, writes.full_drops, writes.clears);
      if (writes.errors == 0 && writes.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
